// ----- hw/rtl/plld_pkg.sv -----
// Package for the packet-line deframer: status codes, phase codes, result
// record and the hex digit decoder. No dependencies.
package plld_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned BUF_W       = 17;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned HEADER_LEN  = 4;
  localparam logic [BUF_W-1:0] BUF_SIZE_RESET = 17'h10000;

  typedef enum logic [STATUS_W-1:0] {
    ST_HEADER  = 3'd0,
    ST_PAYLOAD = 3'd1,
    ST_FLUSH   = 3'd2,
    ST_BADHEX  = 3'd3,
    ST_SHORT   = 3'd4,
    ST_LONG    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALTED  = 2'd2
  } phase_t;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  payload_byte;
    logic [LEN_W-1:0]   payload_length;
    logic               last_of_packet;
  } result_t;

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] value;
  } hex_digit_t;

  // Decodes one ASCII hex digit of either case.
  function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_digit_t d;
    d.ok    = 1'b1;
    d.value = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = c[DIGIT_W-1:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // Letters a-f and A-F share their low three bits: 1..6 map to 10..15.
      d.value = 4'd9 + {1'b0, c[2:0]};
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// ----- hw/rtl/plld_ifs.sv -----
// Channel interfaces of the packet-line deframer: raw byte stream, result
// stream and configuration write channel. Depends on plld_pkg.
interface plld_byte_if;
  logic                          valid;
  logic                          ready;
  logic [plld_pkg::BYTE_W-1:0]   data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface plld_result_if;
  logic                          valid;
  logic                          ready;
  logic [plld_pkg::STATUS_W-1:0] status;
  logic [plld_pkg::BYTE_W-1:0]   payload_byte;
  logic [plld_pkg::LEN_W-1:0]    payload_length;
  logic                          last_of_packet;
  modport source (output valid, output status, output payload_byte,
                  output payload_length, output last_of_packet, input ready);
  modport sink   (input valid, input status, input payload_byte,
                  input payload_length, input last_of_packet, output ready);
endinterface

interface plld_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [plld_pkg::BUF_W-1:0]    buffer_size;
  modport source (output valid, output buffer_size, input ready);
  modport sink   (input valid, input buffer_size, output ready);
endinterface

// ----- hw/rtl/pkt_line_deframer.sv -----
// Packet-line deframer: one stream byte per transfer, zero or one result each.
// Each byte passes the input register, the parser step and the result register.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single-pass parser step; a stalled output holds one more byte.
// Reset (synchronous): header phase, empty registers, buffer size 65536.
// Depends on plld_pkg, plld_ifs, plld_in_stage, plld_parser, plld_out_stage.
module pkt_line_deframer (
  input  logic                 clk,
  input  logic                 rst,
  plld_byte_if.sink            stream,
  plld_result_if.source        result,
  plld_cfg_if.sink             cfg
);

  logic                        held_valid;
  logic [plld_pkg::BYTE_W-1:0] held_byte;
  logic                        step;
  logic                        out_free;
  logic                        res_fire;
  plld_pkg::result_t           res;
  plld_pkg::result_t           out_res;

  assign step      = held_valid && out_free;
  assign cfg.ready = 1'b1;

  plld_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (stream.valid),
    .in_byte    (stream.data_byte),
    .in_ready   (stream.ready),
    .step       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  plld_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg.valid),
    .cfg_buffer_size (cfg.buffer_size),
    .step            (step),
    .data_byte       (held_byte),
    .res_fire        (res_fire),
    .res             (res)
  );

  plld_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res_fire  (res_fire),
    .res       (res),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_res   (out_res),
    .free      (out_free)
  );

  assign result.status         = out_res.status;
  assign result.payload_byte   = out_res.payload_byte;
  assign result.payload_length = out_res.payload_length;
  assign result.last_of_packet = out_res.last_of_packet;

endmodule

// ----- hw/rtl/plld_in_stage.sv -----
// Input register of the packet-line deframer. Holds one accepted byte until
// the parser consumes it. Depends on plld_pkg.
module plld_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [plld_pkg::BYTE_W-1:0] in_byte,
  output logic                        in_ready,
  input  logic                        step,
  output logic                        held_valid,
  output logic [plld_pkg::BYTE_W-1:0] held_byte
);

  assign in_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (step) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

// ----- hw/rtl/plld_parser.sv -----
// Header parser and payload counter of the packet-line deframer, with the
// buffer size register. Depends on plld_pkg.
module plld_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [plld_pkg::BUF_W-1:0]  cfg_buffer_size,
  input  logic                        step,
  input  logic [plld_pkg::BYTE_W-1:0] data_byte,
  output logic                        res_fire,
  output plld_pkg::result_t           res
);

  plld_pkg::phase_t               phase, phase_next;
  logic [1:0]                     digit_count, digit_count_next;
  logic [plld_pkg::LEN_W-1:0]     length_accumulator, length_accumulator_next;
  logic [plld_pkg::LEN_W-1:0]     bytes_remaining, bytes_remaining_next;
  logic [plld_pkg::BUF_W-1:0]     buffer_size;

  plld_pkg::hex_digit_t           digit;
  logic [plld_pkg::LEN_W-1:0]     total;
  logic [plld_pkg::LEN_W-1:0]     plen;
  logic [plld_pkg::LEN_W-1:0]     rem_dec;

  assign digit   = plld_pkg::hex_decode(data_byte);
  assign total   = {length_accumulator[plld_pkg::LEN_W-5:0], digit.value};
  assign plen    = total - plld_pkg::LEN_W'(plld_pkg::HEADER_LEN);
  assign rem_dec = (bytes_remaining != '0) ? bytes_remaining - 1'b1 : bytes_remaining;

  always_comb begin
    phase_next              = phase;
    digit_count_next        = digit_count;
    length_accumulator_next = length_accumulator;
    bytes_remaining_next    = bytes_remaining;
    res_fire                = 1'b0;
    res.status              = plld_pkg::ST_HEADER;
    res.payload_byte        = '0;
    res.payload_length      = '0;
    res.last_of_packet      = 1'b0;
    unique case (phase)
      plld_pkg::PH_HEADER: begin
        if (!digit.ok) begin
          phase_next = plld_pkg::PH_HALTED;
          res_fire   = 1'b1;
          res.status = plld_pkg::ST_BADHEX;
        end else if (digit_count != 2'd3) begin
          digit_count_next        = digit_count + 2'd1;
          length_accumulator_next = total;
        end else begin
          digit_count_next        = '0;
          length_accumulator_next = '0;
          res_fire                = 1'b1;
          if (total == '0) begin
            res.status = plld_pkg::ST_FLUSH;
          end else if (total <= plld_pkg::LEN_W'(plld_pkg::HEADER_LEN)) begin
            phase_next = plld_pkg::PH_HALTED;
            res.status = plld_pkg::ST_SHORT;
          end else if ({1'b0, plen} >= buffer_size) begin
            phase_next = plld_pkg::PH_HALTED;
            res.status = plld_pkg::ST_LONG;
          end else begin
            phase_next           = plld_pkg::PH_PAYLOAD;
            bytes_remaining_next = plen;
            res.status           = plld_pkg::ST_HEADER;
            res.payload_length   = plen;
          end
        end
      end
      plld_pkg::PH_PAYLOAD: begin
        bytes_remaining_next = rem_dec;
        res_fire             = 1'b1;
        res.status           = plld_pkg::ST_PAYLOAD;
        res.payload_byte     = data_byte;
        res.last_of_packet   = (rem_dec == '0);
        if (rem_dec == '0) begin
          phase_next = plld_pkg::PH_HEADER;
        end
      end
      default: begin
        // Halted: bytes are dropped until reset.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= plld_pkg::PH_HEADER;
      digit_count        <= '0;
      length_accumulator <= '0;
      bytes_remaining    <= '0;
    end else if (step) begin
      phase              <= phase_next;
      digit_count        <= digit_count_next;
      length_accumulator <= length_accumulator_next;
      bytes_remaining    <= bytes_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= plld_pkg::BUF_SIZE_RESET;
    end else if (cfg_write) begin
      buffer_size <= cfg_buffer_size;
    end
  end

endmodule

// ----- hw/rtl/plld_out_stage.sv -----
// Result register of the packet-line deframer. Loads a result when the
// parser steps and holds it until the downstream transfer. Depends on plld_pkg.
module plld_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              res_fire,
  input  plld_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output plld_pkg::result_t out_res,
  output logic              free
);

  // The register can take a new result when empty or when its content leaves now.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_fire;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_fire) begin
      out_res <= res;
    end
  end

endmodule
